// File: rtl/wab_pkg.sv
// Shared types, constants and helpers for the windowed alpha blend pixel block.
// Used by the CSR file, the three pipeline stages and the top level.
package wab_pkg;

   localparam int MAX_DIM  = 4096;
   localparam int CFG_DW   = 13;
   localparam int DIM_W    = 14;
   localparam int COORD_W  = 15;
   localparam int PADDR_W  = 5;
   localparam int PDATA_W  = 32;
   localparam logic [8:0] OPACITY_ONE = 9'd256;
   localparam logic [7:0] ALPHA_FULL  = 8'd255;
   localparam logic [7:0] ROUND_MIX   = 8'd127;
   localparam logic [7:0] ROUND_Q8    = 8'd128;

   typedef enum logic [2:0] {
      REG_PLACE_X        = 3'd0,
      REG_PLACE_Y        = 3'd1,
      REG_OVERLAY_WIDTH  = 3'd2,
      REG_OVERLAY_HEIGHT = 3'd3,
      REG_FRAME_WIDTH    = 3'd4,
      REG_FRAME_HEIGHT   = 3'd5,
      REG_OPACITY_Q8     = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic signed [13:0] place_x;
      logic signed [13:0] place_y;
      logic [CFG_DW-1:0]  overlay_width;
      logic [CFG_DW-1:0]  overlay_height;
      logic [CFG_DW-1:0]  frame_width;
      logic [CFG_DW-1:0]  frame_height;
      logic [8:0]         opacity_q8;
   } cfg_type;

   typedef struct packed {
      logic [11:0] pix_x;
      logic [11:0] pix_y;
      logic [7:0]  frame_blue;
      logic [7:0]  frame_green;
      logic [7:0]  frame_red;
      logic [7:0]  frame_alpha;
      logic [7:0]  ovl_blue;
      logic [7:0]  ovl_green;
      logic [7:0]  ovl_red;
      logic [7:0]  ovl_alpha;
   } pixel_type;

   typedef struct packed {
      logic [7:0] frame_blue;
      logic [7:0] frame_green;
      logic [7:0] frame_red;
      logic [7:0] frame_alpha;
      logic [7:0] ovl_blue;
      logic [7:0] ovl_green;
      logic [7:0] ovl_red;
      logic [7:0] alpha;
   } gate_type;

   typedef struct packed {
      logic [15:0] sum_blue;
      logic [15:0] sum_green;
      logic [15:0] sum_red;
      logic [7:0]  frame_blue;
      logic [7:0]  frame_green;
      logic [7:0]  frame_red;
      logic [7:0]  frame_alpha;
      logic        blend;
   } mix_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic [7:0] out_alpha;
      logic       was_blended;
   } result_type;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_DW-1:0] v);
      logic [DIM_W-1:0] ext;
      ext = {{(DIM_W-CFG_DW){1'b0}}, v};
      return (ext > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : ext;
   endfunction

   // exact floor(x / 255) for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] xp;
      logic [16:0] t;
      xp = {1'b0, x} + 17'd1;
      t  = xp + {9'd0, xp[15:8]};
      return t[15:8];
   endfunction

endpackage

// File: rtl/wab_csr.sv
// APB-style configuration register file for the alpha blend block.
// Depends on wab_pkg for the register index codes and the cfg_type struct.
module wab_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [wab_pkg::PADDR_W-1:0] paddr,
   input  logic [wab_pkg::PDATA_W-1:0] pwdata,
   output logic [wab_pkg::PDATA_W-1:0] prdata,
   output logic                      pready,
   output wab_pkg::cfg_type          cfg
);
   import wab_pkg::*;

   cfg_type     cfg_ff;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[PADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.place_x        <= '0;
         cfg_ff.place_y        <= '0;
         cfg_ff.overlay_width  <= '0;
         cfg_ff.overlay_height <= '0;
         cfg_ff.frame_width    <= CFG_DW'(MAX_DIM);
         cfg_ff.frame_height   <= CFG_DW'(MAX_DIM);
         cfg_ff.opacity_q8     <= OPACITY_ONE;
      end else if (wr_en) begin
         case (idx)
            REG_PLACE_X:        cfg_ff.place_x        <= pwdata[13:0];
            REG_PLACE_Y:        cfg_ff.place_y        <= pwdata[13:0];
            REG_OVERLAY_WIDTH:  cfg_ff.overlay_width  <= pwdata[CFG_DW-1:0];
            REG_OVERLAY_HEIGHT: cfg_ff.overlay_height <= pwdata[CFG_DW-1:0];
            REG_FRAME_WIDTH:    cfg_ff.frame_width    <= pwdata[CFG_DW-1:0];
            REG_FRAME_HEIGHT:   cfg_ff.frame_height   <= pwdata[CFG_DW-1:0];
            REG_OPACITY_Q8:     cfg_ff.opacity_q8     <= pwdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_PLACE_X:        prdata = PDATA_W'(cfg_ff.place_x);
         REG_PLACE_Y:        prdata = PDATA_W'(cfg_ff.place_y);
         REG_OVERLAY_WIDTH:  prdata = {{(PDATA_W-CFG_DW){1'b0}}, cfg_ff.overlay_width};
         REG_OVERLAY_HEIGHT: prdata = {{(PDATA_W-CFG_DW){1'b0}}, cfg_ff.overlay_height};
         REG_FRAME_WIDTH:    prdata = {{(PDATA_W-CFG_DW){1'b0}}, cfg_ff.frame_width};
         REG_FRAME_HEIGHT:   prdata = {{(PDATA_W-CFG_DW){1'b0}}, cfg_ff.frame_height};
         REG_OPACITY_Q8:     prdata = {{(PDATA_W-9){1'b0}}, cfg_ff.opacity_q8};
         default:            prdata = '0;
      endcase
   end

endmodule

// File: rtl/wab_gate.sv
// Stage 1: window and frame clipping test, opacity scaling of overlay alpha.
// Depends on wab_pkg for cfg_type, pixel_type, gate_type and sat_dim.
module wab_gate (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  wab_pkg::pixel_type in_pix,
   input  wab_pkg::cfg_type   cfg,
   output logic               out_valid,
   output wab_pkg::gate_type  out_data
);
   import wab_pkg::*;

   logic                      valid_ff;
   gate_type                  data_ff;
   gate_type                  data_in;
   logic signed [COORD_W-1:0] px, py, x0, y0, x1, y1;
   logic signed [COORD_W-1:0] fw, fh;
   logic [8:0]                op;
   logic [16:0]               prod;
   logic                      in_win;

   always_comb begin
      px = COORD_W'(signed'({1'b0, in_pix.pix_x}));
      py = COORD_W'(signed'({1'b0, in_pix.pix_y}));
      x0 = COORD_W'(cfg.place_x);
      y0 = COORD_W'(cfg.place_y);
      x1 = x0 + signed'({1'b0, sat_dim(cfg.overlay_width)});
      y1 = y0 + signed'({1'b0, sat_dim(cfg.overlay_height)});
      fw = signed'({1'b0, sat_dim(cfg.frame_width)});
      fh = signed'({1'b0, sat_dim(cfg.frame_height)});
      in_win = (px >= x0) && (px < x1) && (px < fw) &&
               (py >= y0) && (py < y1) && (py < fh);
      op   = (cfg.opacity_q8 > OPACITY_ONE) ? OPACITY_ONE : cfg.opacity_q8;
      prod = in_pix.ovl_alpha * op + {9'd0, ROUND_Q8};
      data_in.frame_blue  = in_pix.frame_blue;
      data_in.frame_green = in_pix.frame_green;
      data_in.frame_red   = in_pix.frame_red;
      data_in.frame_alpha = in_pix.frame_alpha;
      data_in.ovl_blue    = in_pix.ovl_blue;
      data_in.ovl_green   = in_pix.ovl_green;
      data_in.ovl_red     = in_pix.ovl_red;
      data_in.alpha       = in_win ? prod[15:8] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/wab_mix.sv
// Stage 2: weighted channel sums ovl*a + frame*(255-a) + 127.
// Depends on wab_pkg for gate_type and mix_type.
module wab_mix (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  wab_pkg::gate_type in_data,
   output logic              out_valid,
   output wab_pkg::mix_type  out_data
);
   import wab_pkg::*;

   logic       valid_ff;
   mix_type    data_ff;
   mix_type    data_in;
   logic [7:0] inv;

   always_comb begin
      inv = ALPHA_FULL - in_data.alpha;
      data_in.sum_blue  = in_data.ovl_blue * in_data.alpha + in_data.frame_blue * inv
                          + {8'd0, ROUND_MIX};
      data_in.sum_green = in_data.ovl_green * in_data.alpha + in_data.frame_green * inv
                          + {8'd0, ROUND_MIX};
      data_in.sum_red   = in_data.ovl_red * in_data.alpha + in_data.frame_red * inv
                          + {8'd0, ROUND_MIX};
      data_in.frame_blue  = in_data.frame_blue;
      data_in.frame_green = in_data.frame_green;
      data_in.frame_red   = in_data.frame_red;
      data_in.frame_alpha = in_data.frame_alpha;
      data_in.blend       = (in_data.alpha != 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/wab_div.sv
// Stage 3: divide by 255 and select blended or pass-through result; output register.
// Depends on wab_pkg for mix_type, result_type and div255.
module wab_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  wab_pkg::mix_type    in_data,
   output logic                out_valid,
   output wab_pkg::result_type out_data
);
   import wab_pkg::*;

   logic       valid_ff;
   result_type data_ff;
   result_type data_in;

   always_comb begin
      if (in_data.blend) begin
         data_in.out_blue    = div255(in_data.sum_blue);
         data_in.out_green   = div255(in_data.sum_green);
         data_in.out_red     = div255(in_data.sum_red);
         data_in.out_alpha   = ALPHA_FULL;
         data_in.was_blended = 1'b1;
      end else begin
         data_in.out_blue    = in_data.frame_blue;
         data_in.out_green   = in_data.frame_green;
         data_in.out_red     = in_data.frame_red;
         data_in.out_alpha   = in_data.frame_alpha;
         data_in.was_blended = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/windowed_alpha_blend_pixel.sv
// Top level of the windowed alpha blend pixel block.
// Depends on wab_pkg, wab_csr, wab_gate, wab_mix and wab_div.
//
// Usage:
//   req_* carries one beat per pixel: frame coordinates, the BGRA frame pixel
//   and the overlay pixel at that position. rsp_* returns one beat per pixel
//   in the same order: the BGR result, alpha and a blended flag.
//   Registers (place, overlay size, frame size, opacity) are written through
//   the APB-style port at byte address 4*index; pready is always high.
//   Write them only while the pipeline is empty.
// Timing:
//   Three register stages (clip/opacity, channel products, divide by 255).
//   An accepted beat passes the stage 1, 2 and 3 registers in order, then shows on rsp_*.
//   One beat per cycle sustained while rsp_ready is high; the stages advance on an enable chain.
// Stall:
//   A stage holds while the one after it is full and not moving, so with
//   rsp_ready low the pipeline fills up to three beats, then req_ready drops.
// Reset:
//   Synchronous; empties the pipeline and loads the register defaults.
module windowed_alpha_blend_pixel (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [11:0]                 req_pix_x,
   input  logic [11:0]                 req_pix_y,
   input  logic [7:0]                  req_frame_blue,
   input  logic [7:0]                  req_frame_green,
   input  logic [7:0]                  req_frame_red,
   input  logic [7:0]                  req_frame_alpha,
   input  logic [7:0]                  req_ovl_blue,
   input  logic [7:0]                  req_ovl_green,
   input  logic [7:0]                  req_ovl_red,
   input  logic [7:0]                  req_ovl_alpha,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_blue,
   output logic [7:0]                  rsp_out_green,
   output logic [7:0]                  rsp_out_red,
   output logic [7:0]                  rsp_out_alpha,
   output logic                        rsp_was_blended,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [wab_pkg::PADDR_W-1:0] paddr,
   input  logic [wab_pkg::PDATA_W-1:0] pwdata,
   output logic [wab_pkg::PDATA_W-1:0] prdata,
   output logic                        pready
);
   import wab_pkg::*;

   cfg_type    cfg;
   pixel_type  in_pix;
   gate_type   s1_data;
   mix_type    s2_data;
   result_type s3_data;
   logic       s1_valid, s2_valid, s3_valid;
   logic       en1, en2, en3;

   assign en3 = !s3_valid || rsp_ready;
   assign en2 = !s2_valid || en3;
   assign en1 = !s1_valid || en2;
   assign req_ready = en1;

   always_comb begin
      in_pix.pix_x       = req_pix_x;
      in_pix.pix_y       = req_pix_y;
      in_pix.frame_blue  = req_frame_blue;
      in_pix.frame_green = req_frame_green;
      in_pix.frame_red   = req_frame_red;
      in_pix.frame_alpha = req_frame_alpha;
      in_pix.ovl_blue    = req_ovl_blue;
      in_pix.ovl_green   = req_ovl_green;
      in_pix.ovl_red     = req_ovl_red;
      in_pix.ovl_alpha   = req_ovl_alpha;
   end

   wab_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wab_gate u_gate (
      .clock     (clock),
      .reset     (reset),
      .en        (en1),
      .in_valid  (req_valid),
      .in_pix    (in_pix),
      .cfg       (cfg),
      .out_valid (s1_valid),
      .out_data  (s1_data)
   );

   wab_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .en        (en2),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   wab_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en3),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_data  (s3_data)
   );

   assign rsp_valid       = s3_valid;
   assign rsp_out_blue    = s3_data.out_blue;
   assign rsp_out_green   = s3_data.out_green;
   assign rsp_out_red     = s3_data.out_red;
   assign rsp_out_alpha   = s3_data.out_alpha;
   assign rsp_was_blended = s3_data.was_blended;

   a_beat_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid)
      else $error("accepted beat missing from stage 1");

   a_blend_alpha: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_blended) |-> (rsp_out_alpha == ALPHA_FULL))
      else $error("blended beat without full alpha");

   a_zero_opacity: assert property (@(posedge clock) disable iff (reset)
      (s2_valid && cfg.opacity_q8 == 9'd0) |-> !s2_data.blend)
      else $error("blend flagged at zero opacity");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid && !en2) |=> s2_valid)
      else $error("stage 2 beat lost under stall");

endmodule
